FILE: src/fsbm_pkg.sv
// Shared constants, types and helpers of the full-search block matcher.
package fsbm_pkg;

   localparam int MAX_BLOCK_DIM  = 64;
   localparam int MAX_SEARCH_DIM = 64;
   localparam int REF_ROWS       = 256;
   localparam int REF_COLS       = 128;

   localparam int CFG_W  = 7;
   localparam int KIND_W = 2;
   localparam int ROW_W  = 8;
   localparam int COL_W  = 7;
   localparam int PIX_W  = 8;
   localparam int SAD_W  = 24;
   localparam int OFF_W  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int GROUP_BIT = 3;

   localparam int BDIM_W = $clog2(MAX_BLOCK_DIM + 1);
   localparam int SDIM_W = $clog2(MAX_SEARCH_DIM + 1);
   localparam int BCNT_W = $clog2(MAX_BLOCK_DIM);
   localparam int SCNT_W = (MAX_SEARCH_DIM > 1) ? $clog2(MAX_SEARCH_DIM) : 1;
   localparam int SRC_DEPTH = MAX_BLOCK_DIM * MAX_BLOCK_DIM;
   localparam int SRC_AW = $clog2(SRC_DEPTH);
   localparam int REF_DEPTH = REF_ROWS * REF_COLS;
   localparam int REF_AW = $clog2(REF_DEPTH);
   localparam int RROW_W = $clog2(MAX_SEARCH_DIM + 2 * MAX_BLOCK_DIM);
   localparam int RCOL_W = $clog2(MAX_SEARCH_DIM + MAX_BLOCK_DIM);

   localparam logic [SAD_W-1:0] COST_INIT = 24'hFFFFFF;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARSE_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_STEP      = 3'd5;

   typedef enum logic [KIND_W-1:0] {
      KIND_SRC   = 2'd0,
      KIND_REF   = 2'd1,
      KIND_START = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } eng_state_type;

   typedef struct packed {
      logic [BDIM_W-1:0] bw;
      logic [BDIM_W-1:0] bh;
      logic [SDIM_W-1:0] sw;
      logic [SDIM_W-1:0] sh;
      logic              sparse;
      logic              step2;
   } cfg_type;

   typedef struct packed {
      logic [SAD_W-1:0] sad;
      logic [OFF_W-1:0] x;
      logic [OFF_W-1:0] y;
   } res_type;

   function automatic logic [BDIM_W-1:0] clamp_block(input logic [CFG_W-1:0] v);
      logic [BDIM_W-1:0] r;
      if (v == '0) r = BDIM_W'(1);
      else if (int'(v) > MAX_BLOCK_DIM) r = BDIM_W'(MAX_BLOCK_DIM);
      else r = BDIM_W'(v);
      return r;
   endfunction

   function automatic logic [SDIM_W-1:0] clamp_search(input logic [CFG_W-1:0] v);
      logic [SDIM_W-1:0] r;
      if (v == '0) r = SDIM_W'(1);
      else if (int'(v) > MAX_SEARCH_DIM) r = SDIM_W'(MAX_SEARCH_DIM);
      else r = SDIM_W'(v);
      return r;
   endfunction

endpackage

FILE: src/fsbm_if.sv
// Channel interfaces: request, response and register write.
interface fsbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [fsbm_pkg::KIND_W-1:0] kind;
   logic [fsbm_pkg::ROW_W-1:0]  row;
   logic [fsbm_pkg::COL_W-1:0]  col;
   logic [fsbm_pkg::PIX_W-1:0]  pixel;
   modport source (output valid, kind, row, col, pixel, input ready);
   modport sink (input valid, kind, row, col, pixel, output ready);
endinterface

interface fsbm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fsbm_pkg::SAD_W-1:0] best_sad;
   logic [fsbm_pkg::OFF_W-1:0] best_x;
   logic [fsbm_pkg::OFF_W-1:0] best_y;
   modport source (output valid, best_sad, best_x, best_y, input ready);
   modport sink (input valid, best_sad, best_x, best_y, output ready);
endinterface

interface fsbm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fsbm_pkg::CSR_IDX_W-1:0] index;
   logic [fsbm_pkg::CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/fsbm_ram.sv
// Generic single-port RAM with registered read.
module fsbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/fsbm_engine.sv
// Search sequencer: offset and pixel counters, SAD accumulator, best tracker.
module fsbm_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  fsbm_pkg::cfg_type             cfg,
   output logic                          busy,
   output logic [fsbm_pkg::SRC_AW-1:0]   src_addr,
   output logic [fsbm_pkg::REF_AW-1:0]   ref_addr,
   input  logic [fsbm_pkg::PIX_W-1:0]    src_data,
   input  logic [fsbm_pkg::PIX_W-1:0]    ref_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output fsbm_pkg::res_type             res
);
   fsbm_pkg::eng_state_type state_ff, state_in;

   logic [fsbm_pkg::BCNT_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [fsbm_pkg::SCNT_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic p1_valid_ff, p1_valid_in, p1_last_ff, p1_last_in, p1_oob_ff, p1_oob_in;
   logic [fsbm_pkg::SCNT_W-1:0] p1_sx_ff, p1_sx_in, p1_sy_ff, p1_sy_in;
   logic [fsbm_pkg::SAD_W-1:0] acc_ff, acc_in;
   logic cmp_valid_ff, cmp_valid_in;
   logic [fsbm_pkg::SAD_W-1:0] sad_ff, sad_in;
   logic [fsbm_pkg::SCNT_W-1:0] cmp_sx_ff, cmp_sx_in, cmp_sy_ff, cmp_sy_in;
   logic [fsbm_pkg::SAD_W-1:0] best_cost_ff, best_cost_in;
   logic [fsbm_pkg::OFF_W-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;

   logic [31:0] sx_ext;
   logic skip, last_x, last_y, last_pix, last_sx, last_sy;
   logic [fsbm_pkg::RROW_W-1:0] rrow;
   logic [fsbm_pkg::RCOL_W-1:0] rcol;
   logic [fsbm_pkg::PIX_W-1:0] rpix, diff;
   logic [fsbm_pkg::SAD_W-1:0] sum;

   always_comb begin
      sx_ext   = 32'(sx_ff);
      skip     = cfg.sparse && (sx_ext[fsbm_pkg::GROUP_BIT] != sy_ff[0]);
      last_x   = fsbm_pkg::BDIM_W'(x_ff) == cfg.bw - fsbm_pkg::BDIM_W'(1);
      last_y   = fsbm_pkg::BDIM_W'(y_ff) == cfg.bh - fsbm_pkg::BDIM_W'(1);
      last_pix = last_x && last_y;
      last_sx  = fsbm_pkg::SDIM_W'(sx_ff) == cfg.sw - fsbm_pkg::SDIM_W'(1);
      last_sy  = fsbm_pkg::SDIM_W'(sy_ff) == cfg.sh - fsbm_pkg::SDIM_W'(1);
      rrow = fsbm_pkg::RROW_W'(sy_ff) + (cfg.step2 ? fsbm_pkg::RROW_W'({y_ff, 1'b0})
                                                  : fsbm_pkg::RROW_W'(y_ff));
      rcol = fsbm_pkg::RCOL_W'(sx_ff) + fsbm_pkg::RCOL_W'(x_ff);
      src_addr = fsbm_pkg::SRC_AW'(int'(y_ff) * fsbm_pkg::MAX_BLOCK_DIM + int'(x_ff));
      ref_addr = fsbm_pkg::REF_AW'(int'(rrow) * fsbm_pkg::REF_COLS + int'(rcol));
      rpix = p1_oob_ff ? '0 : ref_data;
      diff = (src_data > rpix) ? src_data - rpix : rpix - src_data;
      sum  = acc_ff + fsbm_pkg::SAD_W'(diff);
   end

   always_comb begin
      state_in    = state_ff;
      x_in = x_ff;  y_in = y_ff;  sx_in = sx_ff;  sy_in = sy_ff;
      p1_valid_in = 1'b0;
      p1_last_in  = last_pix;
      p1_oob_in   = (int'(rrow) >= fsbm_pkg::REF_ROWS) || (int'(rcol) >= fsbm_pkg::REF_COLS);
      p1_sx_in    = sx_ff;
      p1_sy_in    = sy_ff;
      busy        = state_ff != fsbm_pkg::ST_IDLE;
      res_valid   = 1'b0;
      unique case (state_ff)
         fsbm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = fsbm_pkg::ST_SCAN;
               x_in = '0;  y_in = '0;  sx_in = '0;  sy_in = '0;
            end
         end
         fsbm_pkg::ST_SCAN: begin
            if (!skip) begin
               p1_valid_in = 1'b1;
               if (last_x) begin
                  x_in = '0;
                  y_in = last_y ? '0 : y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
            if (skip || last_pix) begin
               if (last_sx) begin
                  sx_in = '0;
                  if (last_sy) state_in = fsbm_pkg::ST_DRAIN;
                  else sy_in = sy_ff + 1'b1;
               end else begin
                  sx_in = sx_ff + 1'b1;
               end
            end
         end
         fsbm_pkg::ST_DRAIN: begin
            if (!p1_valid_ff && !cmp_valid_ff) state_in = fsbm_pkg::ST_DONE;
         end
         fsbm_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) state_in = fsbm_pkg::ST_IDLE;
         end
         default: state_in = fsbm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      cmp_valid_in = 1'b0;
      sad_in       = sum;
      cmp_sx_in    = p1_sx_ff;
      cmp_sy_in    = p1_sy_ff;
      if (p1_valid_ff) begin
         acc_in       = p1_last_ff ? '0 : sum;
         cmp_valid_in = p1_last_ff;
      end
      if (start && !busy) acc_in = '0;
      best_cost_in = best_cost_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      if (start && !busy) begin
         best_cost_in = fsbm_pkg::COST_INIT;
      end else if (cmp_valid_ff && sad_ff < best_cost_ff) begin
         best_cost_in = sad_ff;
         best_x_in    = fsbm_pkg::OFF_W'(cmp_sx_ff);
         best_y_in    = fsbm_pkg::OFF_W'(cmp_sy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsbm_pkg::ST_IDLE;
         p1_valid_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
         best_cost_ff <= fsbm_pkg::COST_INIT;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         cmp_valid_ff <= cmp_valid_in;
         best_cost_ff <= best_cost_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      p1_last_ff <= p1_last_in;
      p1_oob_ff <= p1_oob_in;
      p1_sx_ff  <= p1_sx_in;
      p1_sy_ff  <= p1_sy_in;
      acc_ff    <= acc_in;
      sad_ff    <= sad_in;
      cmp_sx_ff <= cmp_sx_in;
      cmp_sy_ff <= cmp_sy_in;
   end

   assign res.sad = best_cost_ff;
   assign res.x   = best_x_ff;
   assign res.y   = best_y_ff;
endmodule

FILE: src/full_search_block_match_sad.sv
// Top level of the full-search SAD block matcher.
//
//  channel  modport  payload                    purpose
//  req_bus  sink     kind, row, col, pixel      pixel loads and search start
//  rsp_bus  source   best_sad, best_x, best_y   one result per start
//  csr_bus  sink     index, data                register writes, always ready
//
// Pixel loads stream back to back while no search is running.
// A start makes one RAM read of each store per cycle for every evaluated pixel
// (bw*bh per offset) and steps past each skipped sparse offset, then drains
// its pipeline and hands the result to the output register.
// Results sit in an output register; loads continue while it waits.
// Reset is synchronous; the stores are not cleared and hold garbage until written.
module full_search_block_match_sad (
   input logic         clock,
   input logic         reset,
   fsbm_req_if.sink    req_bus,
   fsbm_rsp_if.source  rsp_bus,
   fsbm_csr_if.sink    csr_bus
);
   logic [fsbm_pkg::CFG_W-1:0] bw_ff, bh_ff, sw_ff, sh_ff;
   logic sparse_ff;
   logic [1:0] step_ff;
   fsbm_pkg::cfg_type cfg;

   logic busy, res_valid, res_ready, req_fire, src_we, ref_we;
   logic [fsbm_pkg::SRC_AW-1:0] eng_src_addr, src_addr;
   logic [fsbm_pkg::REF_AW-1:0] eng_ref_addr, ref_addr;
   logic [fsbm_pkg::PIX_W-1:0] src_data, ref_data;
   fsbm_pkg::res_type res, rsp_ff;
   logic rsp_valid_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff     <= fsbm_pkg::CFG_W'(8);
         bh_ff     <= fsbm_pkg::CFG_W'(8);
         sw_ff     <= fsbm_pkg::CFG_W'(16);
         sh_ff     <= fsbm_pkg::CFG_W'(16);
         sparse_ff <= 1'b0;
         step_ff   <= 2'd1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            fsbm_pkg::REG_BLOCK_WIDTH:   bw_ff     <= csr_bus.data;
            fsbm_pkg::REG_BLOCK_HEIGHT:  bh_ff     <= csr_bus.data;
            fsbm_pkg::REG_SEARCH_WIDTH:  sw_ff     <= csr_bus.data;
            fsbm_pkg::REG_SEARCH_HEIGHT: sh_ff     <= csr_bus.data;
            fsbm_pkg::REG_SPARSE_MODE:   sparse_ff <= csr_bus.data[0];
            fsbm_pkg::REG_ROW_STEP:      step_ff   <= csr_bus.data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.bw     = fsbm_pkg::clamp_block(bw_ff);
      cfg.bh     = fsbm_pkg::clamp_block(bh_ff);
      cfg.sw     = fsbm_pkg::clamp_search(sw_ff);
      cfg.sh     = fsbm_pkg::clamp_search(sh_ff);
      cfg.sparse = sparse_ff;
      cfg.step2  = step_ff[1];
   end

   assign req_bus.ready = !busy;
   assign req_fire = req_bus.valid && !busy;
   assign src_we = req_fire && (req_bus.kind == fsbm_pkg::KIND_SRC)
                   && (int'(req_bus.row) < fsbm_pkg::MAX_BLOCK_DIM)
                   && (int'(req_bus.col) < fsbm_pkg::MAX_BLOCK_DIM);
   assign ref_we = req_fire && (req_bus.kind == fsbm_pkg::KIND_REF)
                   && (int'(req_bus.row) < fsbm_pkg::REF_ROWS)
                   && (int'(req_bus.col) < fsbm_pkg::REF_COLS);
   assign src_addr = busy ? eng_src_addr : fsbm_pkg::SRC_AW'(
      int'(req_bus.row) * fsbm_pkg::MAX_BLOCK_DIM + int'(req_bus.col));
   assign ref_addr = busy ? eng_ref_addr : fsbm_pkg::REF_AW'(
      int'(req_bus.row) * fsbm_pkg::REF_COLS + int'(req_bus.col));

   fsbm_ram #(.WIDTH(fsbm_pkg::PIX_W), .DEPTH(fsbm_pkg::SRC_DEPTH)) u_src_ram (
      .clock (clock), .we (src_we), .addr (src_addr),
      .wdata (req_bus.pixel), .rdata (src_data)
   );

   fsbm_ram #(.WIDTH(fsbm_pkg::PIX_W), .DEPTH(fsbm_pkg::REF_DEPTH)) u_ref_ram (
      .clock (clock), .we (ref_we), .addr (ref_addr),
      .wdata (req_bus.pixel), .rdata (ref_data)
   );

   fsbm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire && (req_bus.kind == fsbm_pkg::KIND_START)),
      .cfg       (cfg),
      .busy      (busy),
      .src_addr  (eng_src_addr),
      .ref_addr  (eng_ref_addr),
      .src_data  (src_data),
      .ref_data  (ref_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (res_ready) rsp_valid_ff <= res_valid;
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) rsp_ff <= res;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.best_sad = rsp_ff.sad;
   assign rsp_bus.best_x   = rsp_ff.x;
   assign rsp_bus.best_y   = rsp_ff.y;
endmodule

FILE: src/fsbm_checker.sv
// Port-level assertions for the block matcher, bound to the top level.
module fsbm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [fsbm_pkg::KIND_W-1:0] req_kind,
   input logic                        rsp_valid,
   input logic                        rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == fsbm_pkg::KIND_START) |=> !req_ready)
      else $error("request taken during search");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without a search in progress");
endmodule

bind full_search_block_match_sad fsbm_checker u_fsbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_kind  (req_bus.kind),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
